/* rtl/core/postfix_expression_evaluator_assert.svh */
// Assertion macros for the postfix expression evaluator checker.
// Users must provide signals named clk and arst_n in the including scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pfe_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// No dependencies; the interfaces and all modules import this package.
`default_nettype none

package pfe_pkg;

	localparam int DATA_W = 32;
	localparam int CHAR_W = 8;
	localparam int ERR_W  = 2;

	// Status codes reported with each result.
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;
	localparam logic [ERR_W-1:0] ERR_DIVZERO   = 2'd3;

	// Token characters.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/pfe_if.sv */
// Valid/ready channel interfaces for tokens and results.
// Depends on pfe_pkg for field widths.
`default_nettype none

interface pfe_token_if;
	import pfe_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] token_char;

	modport source (output valid, output token_char, input ready);
	modport sink   (input valid, input token_char, output ready);
endinterface

interface pfe_result_if;
	import pfe_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [ERR_W-1:0]         status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink   (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/postfix_expression_evaluator.sv */
// Postfix evaluator: a digit is pushed when taken; '+', '-', '*' or '/' reads two
// entries, runs the shared unit (its divider retires one quotient bit per cycle)
// and writes the result back; ')' loads the result register once it is free.
// The block takes one token at a time; the next token follows once the current is done.
// Asynchronous active-low reset empties the stack, clears the error and the result
// valid flag. Stack entries keep no reset value; only written entries are ever read.
`default_nettype none

module postfix_expression_evaluator
	import pfe_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pfe_token_if.sink    token,
	pfe_result_if.source result
);

	// Count holds 0..STACK_DEPTH; the address indexes the entries.
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDB  = 3'd1;
	localparam logic [2:0] S_EXE  = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [ERR_W-1:0]  err_q;
	alu_op_t           op_q;
	logic [DATA_W-1:0] a_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic [ERR_W-1:0]         status_q;

	// Token decode.
	logic    is_digit;
	logic    is_op;
	logic    is_close;
	alu_op_t tok_op;
	logic    tok_xfer;

	// Stack and unit connections.
	logic              st_we;
	logic [AW-1:0]     st_waddr;
	logic [DATA_W-1:0] st_wdata;
	logic              st_re;
	logic [AW-1:0]     st_raddr;
	logic [DATA_W-1:0] st_rdata;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [DATA_W-1:0] alu_result;

	logic [CW-1:0]    count_m1;
	logic [CW-1:0]    count_m2;
	logic             full;
	logic             err_set;
	logic [ERR_W-1:0] err_code;
	logic             out_free;

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);
	assign full     = count_q >= CW'(STACK_DEPTH);
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		is_digit = (token.token_char >= CHAR_ZERO) && (token.token_char <= CHAR_NINE);
		is_close = token.token_char == CHAR_CLOSE;
		is_op    = 1'b1;
		tok_op   = OP_ADD;
		unique case (token.token_char)
			CHAR_PLUS:  tok_op = OP_ADD;
			CHAR_MINUS: tok_op = OP_SUB;
			CHAR_STAR:  tok_op = OP_MUL;
			CHAR_SLASH: tok_op = OP_DIV;
			default:    is_op  = 1'b0;
		endcase
	end

	// New tokens are taken only while the sequencer is idle; a result waiting in
	// the output register does not hold off digits or operators.
	assign token.ready = state_q == S_IDLE;
	assign tok_xfer    = token.valid && token.ready;

	// Stack port, unit start and error reporting for each state.
	always_comb begin
		st_we    = 1'b0;
		st_waddr = count_q[AW-1:0];
		st_wdata = DATA_W'(token.token_char - CHAR_ZERO);
		st_re    = 1'b0;
		st_raddr = count_m1[AW-1:0];
		alu_req  = '{start: 1'b0, op: op_q};
		err_set  = 1'b0;
		err_code = ERR_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (tok_xfer) begin
					if (is_digit) begin
						if (full) begin
							err_set  = 1'b1;
							err_code = ERR_OVERFLOW;
						end else begin
							st_we = 1'b1;
						end
					end else if (is_op) begin
						if (count_q < CW'(2)) begin
							err_set  = 1'b1;
							err_code = ERR_UNDERFLOW;
						end else begin
							st_re = 1'b1;
						end
					end else if (is_close) begin
						if (count_q == '0) begin
							err_set  = 1'b1;
							err_code = ERR_UNDERFLOW;
						end else begin
							st_re = 1'b1;
						end
					end
				end
			end
			S_RDB: begin
				// Top entry is on the read port; fetch the one below it.
				st_re    = 1'b1;
				st_raddr = count_m2[AW-1:0];
			end
			S_EXE: begin
				alu_req.start = 1'b1;
			end
			S_WAIT: begin
				// The result replaces the lower operand, and the stack shrinks by one.
				st_waddr = count_m2[AW-1:0];
				st_wdata = alu_result;
				if (alu_rsp.done) begin
					st_we = 1'b1;
					if (alu_rsp.div_zero) begin
						err_set  = 1'b1;
						err_code = ERR_DIVZERO;
					end
				end
			end
			S_EMIT: begin
				st_re = 1'b0;
			end
			default: begin
				st_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ERR_NONE;
			op_q        <= OP_ADD;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register as soon as it is free;
			// otherwise a transfer empties it.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// The first error sticks until a ')' reports it.
			if (err_set && (err_q == ERR_NONE)) begin
				err_q <= err_code;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tok_xfer) begin
						if (is_digit && !full) begin
							count_q <= count_q + CW'(1);
						end else if (is_op && (count_q >= CW'(2))) begin
							op_q    <= tok_op;
							state_q <= S_RDB;
						end else if (is_close) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_RDB:  state_q <= S_EXE;
				S_EXE:  state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_rsp.done) begin
						count_q <= count_m1;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						count_q <= '0;
						err_q   <= ERR_NONE;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The top entry, the right-hand operand, is captured while the one below it is read.
	always_ff @(posedge clk) begin
		if (state_q == S_RDB) begin
			a_q <= st_rdata;
		end
		if ((state_q == S_EMIT) && out_free) begin
			result_value_q <= (err_q != ERR_NONE) ? '0 : st_rdata;
			status_q       <= err_q;
		end
	end

	pfe_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	pfe_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opnd_a(a_q),
		.opnd_b(st_rdata),
		.rsp   (alu_rsp),
		.result(alu_result)
	);

	assign result.valid        = out_valid_q;
	assign result.result_value = result_value_q;
	assign result.status       = status_q;

endmodule

`default_nettype wire

/* rtl/core/pfe_stack.sv */
// Operand stack storage: one write port and one registered read port.
// Depends on pfe_pkg for the data width.
`default_nettype none

module pfe_stack
	import pfe_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pfe_alu.sv */
// Shared arithmetic unit: registered add, subtract and multiply, and a
// restoring divider that retires one quotient bit per cycle. Uses pfe_pkg.
`default_nettype none

module pfe_alu
	import pfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_req_t          req,
	input  wire logic [DATA_W-1:0] opnd_a,
	input  wire logic [DATA_W-1:0] opnd_b,
	output alu_rsp_t               rsp,
	output logic      [DATA_W-1:0] result
);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_DIV  = 2'd1;
	localparam logic [1:0] A_FIX  = 2'd2;
	localparam int SW = $clog2(DATA_W);

	logic [1:0]        state_q;
	logic [SW-1:0]     step_q;
	logic              done_q;
	logic              dz_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;

	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W-1:0] shifted;
	logic [DATA_W-1:0] diff;
	logic              fits;

	assign mag_a   = opnd_a[DATA_W-1] ? (DATA_W'(0) - opnd_a) : opnd_a;
	assign mag_b   = opnd_b[DATA_W-1] ? (DATA_W'(0) - opnd_b) : opnd_b;
	// The remainder stays below the divisor, which is at most 2^31, so the
	// shifted remainder still fits in the data width.
	assign shifted = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign diff    = shifted - dvs_q;
	assign fits    = shifted >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
		end else begin
			// Add, subtract, multiply and a zero divisor finish at once; a real divide
			// finishes with the sign fix: done is registered together with the fixed quotient.
			done_q <= ((state_q == A_IDLE) && req.start &&
				((req.op != OP_DIV) || (opnd_a == '0))) || (state_q == A_FIX);
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						dz_q <= (req.op == OP_DIV) && (opnd_a == '0);
						if ((req.op == OP_DIV) && (opnd_a != '0)) begin
							step_q  <= SW'(DATA_W - 1);
							state_q <= A_DIV;
						end
					end
				end
				A_DIV: begin
					if (step_q == '0) begin
						state_q <= A_FIX;
					end else begin
						step_q <= step_q - SW'(1);
					end
				end
				A_FIX: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						OP_ADD: res_q <= opnd_b + opnd_a;
						OP_SUB: res_q <= opnd_b - opnd_a;
						OP_MUL: res_q <= opnd_b * opnd_a;
						OP_DIV: begin
							res_q <= '0;
							rem_q <= '0;
							quo_q <= mag_b;
							dvs_q <= mag_a;
							neg_q <= opnd_b[DATA_W-1] ^ opnd_a[DATA_W-1];
						end
						default: res_q <= '0;
					endcase
				end
			end
			A_DIV: begin
				rem_q <= fits ? diff : shifted;
				quo_q <= {quo_q[DATA_W-2:0], fits};
			end
			A_FIX: begin
				res_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign result       = res_q;

endmodule

`default_nettype wire

/* rtl/core/pfe_checker.sv */
// Port-level checker for the postfix expression evaluator and its bind.
// Depends on pfe_pkg and postfix_expression_evaluator_assert.svh.
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pfe_checker
	import pfe_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     tok_valid,
	input wire logic                     tok_ready,
	input wire logic [CHAR_W-1:0]        tok_char,
	input wire logic                     res_valid,
	input wire logic                     res_ready,
	input wire logic signed [DATA_W-1:0] res_value,
	input wire logic [ERR_W-1:0]         res_status
);

	`PFE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_status), "result changed while stalled")
	`PFE_ASSERT_IMP(a_err_zero, res_valid && (res_status != ERR_NONE), res_value == '0, "errored result has nonzero value")
	`PFE_ASSERT_NXT(a_close_busy, tok_valid && tok_ready && (tok_char == CHAR_CLOSE), !tok_ready, "token taken right after a close")
	`PFE_ASSERT_IMP(a_res_rise, $rose(res_valid), $past(!tok_ready), "result appeared while input side was idle")

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (token.valid),
	.tok_ready (token.ready),
	.tok_char  (token.token_char),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_value (result.result_value),
	.res_status(result.status)
);

`default_nettype wire
